// ===== design/parabola_breakpoint_solver_core_macros.svh =====
// Assertion macros shared by the breakpoint solver RTL.
// Each macro checks one implication on the rising edge of clk, disabled in reset.
`ifndef PARABOLA_BREAKPOINT_SOLVER_CORE_MACROS_SVH
`define PARABOLA_BREAKPOINT_SOLVER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("breakpoint solver check failed");
// Next-cycle implication.
`define PBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("breakpoint solver check failed");
`else
`define PBS_ASSERT_IMP(lbl, ante, cons)
`define PBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/pbs_pkg.sv =====
package pbs_pkg;

	// Default geometry of the coordinates.
	localparam int DEF_FRAC_BITS   = 16;
	localparam int DEF_COORD_WIDTH = 32;

	// Configuration registers.
	localparam int TOL_WIDTH = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCUS_TOL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DISC_TOL  = 1'b1;

	// Status codes of a result word.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_REAL = 2'd1;
	localparam logic [1:0] ST_BOTH_ON = 2'd2;

	// How the breakpoint of one word is found.
	typedef enum logic [1:0] {
		KIND_GEN,
		KIND_FIXED,
		KIND_ZERO
	} kind_t;

endpackage

// ===== design/pbs_div_cell.sv =====
module pbs_div_cell import pbs_pkg::*; #(
	parameter int NUM_W  = 8,
	parameter int DEN_W  = 8,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [DEN_W-1:0]  out_rem,
	output logic [NUM_W-1:0]  out_num,
	output logic [DEN_W-1:0]  out_den,
	output logic [SIDE_W-1:0] out_side
);

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic             vld_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [SIDE_W-1:0] side_q;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {in_rem, in_num[NUM_W-1]};
	assign diff  = trial - {1'b0, in_den};
	assign ge    = (trial >= {1'b0, in_den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	// The quotient bit enters at the bottom as the dividend leaves at the top.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q  <= {in_num[NUM_W-2:0], ge};
			den_q  <= in_den;
			side_q <= in_side;
		end
	end

	assign out_vld  = vld_q;
	assign out_rem  = rem_q;
	assign out_num  = num_q;
	assign out_den  = den_q;
	assign out_side = side_q;

endmodule

// ===== design/pbs_root_cell.sv =====
module pbs_root_cell import pbs_pkg::*; #(
	parameter int ROOT_W = 8,
	parameter int SIDE_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [1:0][2*ROOT_W-1:0]  in_rad,
	input  logic [1:0][ROOT_W+1:0]    in_rem,
	input  logic [1:0][ROOT_W-1:0]    in_root,
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_vld,
	output logic [1:0][2*ROOT_W-1:0]  out_rad,
	output logic [1:0][ROOT_W+1:0]    out_rem,
	output logic [1:0][ROOT_W-1:0]    out_root,
	output logic [SIDE_W-1:0]         out_side
);

	localparam int RAD_W = 2 * ROOT_W;

	logic [1:0][ROOT_W+3:0] cat_c;
	logic [1:0][ROOT_W+3:0] sub_c;
	logic [1:0][ROOT_W+3:0] dif_c;
	logic [1:0]             ge_c;
	logic                   vld_q;
	logic [1:0][RAD_W-1:0]  rad_q;
	logic [1:0][ROOT_W+1:0] rem_q;
	logic [1:0][ROOT_W-1:0] root_q;
	logic [SIDE_W-1:0]      side_q;

	// One root digit per lane: bring down two radicand bits, try 4*root+1.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cat_c[l] = {in_rem[l], in_rad[l][RAD_W-1 -: 2]};
			sub_c[l] = {2'b00, in_root[l], 2'b01};
			dif_c[l] = cat_c[l] - sub_c[l];
			ge_c[l]  = (cat_c[l] >= sub_c[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				rad_q[l]  <= {in_rad[l][RAD_W-3:0], 2'b00};
				rem_q[l]  <= ge_c[l] ? dif_c[l][ROOT_W+1:0] : cat_c[l][ROOT_W+1:0];
				root_q[l] <= {in_root[l][ROOT_W-2:0], ge_c[l]};
			end
			side_q <= in_side;
		end
	end

	assign out_vld  = vld_q;
	assign out_rad  = rad_q;
	assign out_rem  = rem_q;
	assign out_root = root_q;
	assign out_side = side_q;

endmodule

// ===== design/parabola_breakpoint_solver_core.sv =====
// Breakpoint solver for two parabolas that share a vertical sweep line.
// Input channel: item_valid / item_stall with the directrix and both foci in
// signed fixed point. Output channel: point_valid / point_stall with the
// breakpoint and a status code (ok, no real intersection, both foci on line).
// Configuration: cfg_write_en with cfg_index selects the focus tolerance (0)
// or the discriminant tolerance (1); write them only while no word is in flight.
// Every word passes a fixed chain of 5*COORD_WIDTH + 3*FRAC_BITS + 35 register
// stages, the last of them the output register (coordinates default to Q16.16).
// The length comes from the restoring divider cells (tolerance limit, y quotient,
// x quotient) and the square root cells, one bit or digit per cell.
// One word is accepted every cycle while the output is not held.
// While the output word is stalled the whole chain holds and item_stall is
// high in that same cycle; nothing is dropped. Reset clears every valid bit
// and both tolerance registers to zero.
`include "parabola_breakpoint_solver_core_macros.svh"
module parabola_breakpoint_solver_core import pbs_pkg::*; #(
	parameter int FRAC_BITS   = DEF_FRAC_BITS,
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [TOL_WIDTH-1:0]          cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [COORD_WIDTH-1:0] directrix_x,
	input  logic signed [COORD_WIDTH-1:0] focus1_x,
	input  logic signed [COORD_WIDTH-1:0] focus1_y,
	input  logic signed [COORD_WIDTH-1:0] focus2_x,
	input  logic signed [COORD_WIDTH-1:0] focus2_y,
	output logic                          point_valid,
	input  logic                          point_stall,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic [1:0]                    status
);

	localparam int W   = COORD_WIDTH;
	localparam int MW  = W + 1;
	localparam int PPW = 2 * MW;
	localparam int SW  = 2 * MW + 1;
	localparam int K   = MW + 1;
	localparam int RW  = 2 * K;
	localparam int NYW = 2 * MW + 2;
	localparam int YSW = NYW + 1;
	localparam int LSH = 3 * FRAC_BITS - 2;
	localparam int LNW = TOL_WIDTH + LSH;
	localparam int CW  = (LNW > SW) ? LNW : SW;
	localparam int PDW = MW + 1;
	localparam int PSW = PPW + 2;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		kind_t                 kind;
		logic [1:0]            status;
		logic signed [W-1:0]   y_fix;
		logic signed [W-1:0]   pyf;
		logic                  pneg;
		logic [PDW-1:0]        pden;
		logic signed [W-1:0]   hf;
	} tail_t;

	typedef struct packed {
		tail_t                 tail;
		logic [SW-1:0]         s;
		logic signed [NYW-1:0] n;
		logic [PPW-1:0]        pp;
		logic                  dxneg;
		logic [MW-1:0]         mdx;
	} lim_side_t;

	typedef struct packed {
		tail_t                 tail;
		logic                  big;
		logic signed [NYW-1:0] n;
		logic                  dxneg;
		logic [MW-1:0]         mdx;
	} root_side_t;

	typedef struct packed {
		tail_t tail;
		logic  qneg;
	} y_side_t;

	typedef struct packed {
		tail_t               tail;
		logic signed [W-1:0] y;
	} x_side_t;

	localparam int LSW = $bits(lim_side_t);
	localparam int RSW = $bits(root_side_t);
	localparam int YDW = $bits(y_side_t);
	localparam int XSW = $bits(x_side_t);

	logic adv;
	logic [TOL_WIDTH-1:0] foc_tol_q;
	logic [TOL_WIDTH-1:0] disc_tol_q;

	// Whole chain moves unless the output word is held.
	assign adv        = !(point_valid && point_stall);
	assign item_stall = !adv;

	// Tolerance registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foc_tol_q  <= '0;
			disc_tol_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_FOCUS_TOL: foc_tol_q  <= cfg_data;
				REG_DISC_TOL:  disc_tol_q <= cfg_data;
				default:       foc_tol_q  <= foc_tol_q;
			endcase
		end
	end

	// Valid bits of the plain stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12;
	logic lim_vld [0:LNW];
	logic rt_vld [0:K];
	logic yd_vld [0:NYW];
	logic xd_vld [0:PPW];

	// Stage 1: input word.
	logic signed [W-1:0] xd_s1, xf1_s1, yf1_s1, xf2_s1, yf2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			xd_s1  <= directrix_x;
			xf1_s1 <= focus1_x;
			yf1_s1 <= focus1_y;
			xf2_s1 <= focus2_x;
			yf2_s1 <= focus2_y;
		end
	end

	// Stage 2: focus offsets, case decode and the parabola used for x.
	logic signed [MW-1:0] p1_c, p2_c, dx_c, dy_c, psel_c, ysum_c, hsum_c;
	logic [MW-1:0]        mp1_c, mp2_c, mdx_c, mdy_c, mpsel_c;
	logic                 on1_c, on2_c;
	tail_t                tail_c;

	assign p1_c   = MW'(xf1_s1) - MW'(xd_s1);
	assign p2_c   = MW'(xf2_s1) - MW'(xd_s1);
	assign dx_c   = MW'(xf2_s1) - MW'(xf1_s1);
	assign dy_c   = MW'(yf2_s1) - MW'(yf1_s1);
	assign mp1_c  = p1_c[MW-1] ? MW'(-p1_c) : MW'(p1_c);
	assign mp2_c  = p2_c[MW-1] ? MW'(-p2_c) : MW'(p2_c);
	assign mdx_c  = dx_c[MW-1] ? MW'(-dx_c) : MW'(dx_c);
	assign mdy_c  = dy_c[MW-1] ? MW'(-dy_c) : MW'(dy_c);
	assign on1_c  = (mp1_c <= MW'(foc_tol_q));
	assign on2_c  = (mp2_c <= MW'(foc_tol_q));
	assign psel_c = on1_c ? p2_c : p1_c;
	assign mpsel_c = on1_c ? mp2_c : mp1_c;
	assign ysum_c = MW'(yf1_s1) + MW'(yf2_s1);
	assign hsum_c = on1_c ? (MW'(xf2_s1) + MW'(xd_s1)) : (MW'(xf1_s1) + MW'(xd_s1));

	always_comb begin
		tail_c.kind   = KIND_GEN;
		tail_c.status = ST_OK;
		tail_c.y_fix  = ysum_c[MW-1:1];
		tail_c.pyf    = on1_c ? yf2_s1 : yf1_s1;
		tail_c.pneg   = psel_c[MW-1];
		tail_c.pden   = {mpsel_c, 1'b0};
		tail_c.hf     = hsum_c[MW-1:1];
		priority if (on1_c && on2_c) begin
			tail_c.kind   = KIND_ZERO;
			tail_c.status = ST_BOTH_ON;
		end else if (on1_c) begin
			tail_c.kind  = KIND_FIXED;
			tail_c.y_fix = yf1_s1;
		end else if (on2_c) begin
			tail_c.kind  = KIND_FIXED;
			tail_c.y_fix = yf2_s1;
		end else if (xf1_s1 == xf2_s1) begin
			tail_c.kind = KIND_FIXED;
		end else if (p1_c[MW-1] ^ p2_c[MW-1]) begin
			tail_c.kind   = KIND_ZERO;
			tail_c.status = ST_NO_REAL;
		end else begin
			tail_c.kind = KIND_GEN;
		end
	end

	tail_t               tail_s2;
	logic [MW-1:0]       mp1_s2, mp2_s2, mdx_s2, mdy_s2;
	logic                dxneg_s2;
	logic signed [MW-1:0] p1_s2, p2_s2;
	logic signed [W-1:0] yf1_s2, yf2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s2  <= tail_c;
			mp1_s2   <= mp1_c;
			mp2_s2   <= mp2_c;
			mdx_s2   <= mdx_c;
			mdy_s2   <= mdy_c;
			dxneg_s2 <= dx_c[MW-1];
			p1_s2    <= p1_c;
			p2_s2    <= p2_c;
			yf1_s2   <= yf1_s1;
			yf2_s2   <= yf2_s1;
		end
	end

	// Stage 3: products for the discriminant and the linear term.
	tail_t                  tail_s3;
	logic [PPW-1:0]         pp_s3, dx2_s3, dy2_s3;
	logic signed [MW+W-1:0] a_s3, b_s3;
	logic                   dxneg_s3;
	logic [MW-1:0]          mdx_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s3  <= tail_s2;
			pp_s3    <= mp1_s2 * mp2_s2;
			dx2_s3   <= mdx_s2 * mdx_s2;
			dy2_s3   <= mdy_s2 * mdy_s2;
			a_s3     <= p2_s2 * yf1_s2;
			b_s3     <= p1_s2 * yf2_s2;
			dxneg_s3 <= dxneg_s2;
			mdx_s3   <= mdx_s2;
		end
	end

	// Stage 4: squared distance and numerator.
	lim_side_t lside_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			lside_s4.tail  <= tail_s3;
			lside_s4.s     <= SW'(dx2_s3) + SW'(dy2_s3);
			lside_s4.n     <= NYW'(a_s3) - NYW'(b_s3);
			lside_s4.pp    <= pp_s3;
			lside_s4.dxneg <= dxneg_s3;
			lside_s4.mdx   <= mdx_s3;
		end
	end

	// Tolerance limit: scaled discriminant tolerance divided by p1*p2.
	logic [PPW-1:0] lim_rem  [0:LNW];
	logic [LNW-1:0] lim_num  [0:LNW];
	logic [PPW-1:0] lim_den  [0:LNW];
	logic [LSW-1:0] lim_side [0:LNW];

	assign lim_vld[0]  = v_s4;
	assign lim_rem[0]  = '0;
	assign lim_num[0]  = {disc_tol_q, {LSH{1'b0}}};
	assign lim_den[0]  = lside_s4.pp;
	assign lim_side[0] = lside_s4;

	for (genvar i = 0; i < LNW; i++) begin : g_lim
		pbs_div_cell #(.NUM_W(LNW), .DEN_W(PPW), .SIDE_W(LSW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (lim_vld[i]),
			.in_rem   (lim_rem[i]),
			.in_num   (lim_num[i]),
			.in_den   (lim_den[i]),
			.in_side  (lim_side[i]),
			.out_vld  (lim_vld[i+1]),
			.out_rem  (lim_rem[i+1]),
			.out_num  (lim_num[i+1]),
			.out_den  (lim_den[i+1]),
			.out_side (lim_side[i+1])
		);
	end

	// Stage 5: decide between one and two roots.
	lim_side_t  lside_end;
	root_side_t rside_s5;
	logic [PPW-1:0] pp_s5;
	logic [SW-1:0]  s_s5;

	assign lside_end = lim_side[LNW];

	always_ff @(posedge clk) begin
		if (adv) begin
			rside_s5.tail  <= lside_end.tail;
			rside_s5.big   <= (CW'(lim_num[LNW]) < CW'(lside_end.s));
			rside_s5.n     <= lside_end.n;
			rside_s5.dxneg <= lside_end.dxneg;
			rside_s5.mdx   <= lside_end.mdx;
			pp_s5          <= lside_end.pp;
			s_s5           <= lside_end.s;
		end
	end

	// Square roots of p1*p2 and of the squared distance, one digit per cell.
	logic [1:0][RW-1:0]  rt_rad  [0:K];
	logic [1:0][K+1:0]   rt_rem  [0:K];
	logic [1:0][K-1:0]   rt_root [0:K];
	logic [RSW-1:0]      rt_side [0:K];

	assign rt_vld[0]  = v_s5;
	assign rt_rad[0]  = {RW'(s_s5), RW'(pp_s5)};
	assign rt_rem[0]  = '0;
	assign rt_root[0] = '0;
	assign rt_side[0] = rside_s5;

	for (genvar i = 0; i < K; i++) begin : g_root
		pbs_root_cell #(.ROOT_W(K), .SIDE_W(RSW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (rt_vld[i]),
			.in_rad   (rt_rad[i]),
			.in_rem   (rt_rem[i]),
			.in_root  (rt_root[i]),
			.in_side  (rt_side[i]),
			.out_vld  (rt_vld[i+1]),
			.out_rad  (rt_rad[i+1]),
			.out_rem  (rt_rem[i+1]),
			.out_root (rt_root[i+1]),
			.out_side (rt_side[i+1])
		);
	end

	// Stage 6: product of the two roots.
	root_side_t     rside_s6;
	logic [2*K-1:0] prod_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			rside_s6 <= rt_side[K];
			prod_s6  <= rt_root[K][0] * rt_root[K][1];
		end
	end

	// Stage 7: final numerator.
	root_side_t            rside_s7;
	logic signed [NYW-1:0] n2_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			rside_s7 <= rside_s6;
			n2_s7    <= rside_s6.big ? (rside_s6.n + NYW'(prod_s6)) : rside_s6.n;
		end
	end

	// Stage 8: magnitude and quotient sign.
	y_side_t        yside_s8;
	logic [NYW-1:0] nm_s8;
	logic [MW-1:0]  mdx_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			yside_s8.tail <= rside_s7.tail;
			yside_s8.qneg <= n2_s7[NYW-1] ^ rside_s7.dxneg;
			nm_s8         <= n2_s7[NYW-1] ? NYW'(-n2_s7) : NYW'(n2_s7);
			mdx_s8        <= rside_s7.mdx;
		end
	end

	// Quotient of the numerator by the focus x distance.
	logic [MW-1:0]  yd_rem  [0:NYW];
	logic [NYW-1:0] yd_num  [0:NYW];
	logic [MW-1:0]  yd_den  [0:NYW];
	logic [YDW-1:0] yd_side [0:NYW];

	assign yd_vld[0]  = v_s8;
	assign yd_rem[0]  = '0;
	assign yd_num[0]  = nm_s8;
	assign yd_den[0]  = mdx_s8;
	assign yd_side[0] = yside_s8;

	for (genvar i = 0; i < NYW; i++) begin : g_ydiv
		pbs_div_cell #(.NUM_W(NYW), .DEN_W(MW), .SIDE_W(YDW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (yd_vld[i]),
			.in_rem   (yd_rem[i]),
			.in_num   (yd_num[i]),
			.in_den   (yd_den[i]),
			.in_side  (yd_side[i]),
			.out_vld  (yd_vld[i+1]),
			.out_rem  (yd_rem[i+1]),
			.out_num  (yd_num[i+1]),
			.out_den  (yd_den[i+1]),
			.out_side (yd_side[i+1])
		);
	end

	// Stage 9: signed, saturated y and selection of the fixed cases.
	y_side_t               yside_end;
	logic signed [YSW-1:0] ys_c;
	logic                  ovy_c;
	logic signed [W-1:0]   ygen_c;
	tail_t                 tail_s9;
	logic signed [W-1:0]   y_s9;

	assign yside_end = yd_side[NYW];
	assign ys_c      = yside_end.qneg ? YSW'(-{1'b0, yd_num[NYW]}) : YSW'({1'b0, yd_num[NYW]});
	assign ovy_c     = !((&ys_c[YSW-1:W-1]) || !(|ys_c[YSW-1:W-1]));
	assign ygen_c    = ovy_c ? (ys_c[YSW-1] ? MINV : MAXV) : ys_c[W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s9 <= yside_end.tail;
			y_s9    <= (yside_end.tail.kind == KIND_GEN) ? ygen_c : yside_end.tail.y_fix;
		end
	end

	// Stage 10: distance of y from the chosen focus.
	logic signed [MW-1:0] dyf_c;
	tail_t                tail_s10;
	logic signed [W-1:0]  y_s10;
	logic [MW-1:0]        m_s10;

	assign dyf_c = MW'(y_s9) - MW'(tail_s9.pyf);

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s10 <= tail_s9;
			y_s10    <= y_s9;
			m_s10    <= dyf_c[MW-1] ? MW'(-dyf_c) : MW'(dyf_c);
		end
	end

	// Stage 11: square of that distance.
	x_side_t        xside_s11;
	logic [PPW-1:0] m2_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			xside_s11.tail <= tail_s10;
			xside_s11.y    <= y_s10;
			m2_s11         <= m_s10 * m_s10;
		end
	end

	// Parabola offset: squared distance divided by twice the focus offset.
	logic [PDW-1:0] xd_rem  [0:PPW];
	logic [PPW-1:0] xd_num  [0:PPW];
	logic [PDW-1:0] xd_den  [0:PPW];
	logic [XSW-1:0] xd_side [0:PPW];

	assign xd_vld[0]  = v_s11;
	assign xd_rem[0]  = '0;
	assign xd_num[0]  = m2_s11;
	assign xd_den[0]  = xside_s11.tail.pden;
	assign xd_side[0] = xside_s11;

	for (genvar i = 0; i < PPW; i++) begin : g_xdiv
		pbs_div_cell #(.NUM_W(PPW), .DEN_W(PDW), .SIDE_W(XSW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (xd_vld[i]),
			.in_rem   (xd_rem[i]),
			.in_num   (xd_num[i]),
			.in_den   (xd_den[i]),
			.in_side  (xd_side[i]),
			.out_vld  (xd_vld[i+1]),
			.out_rem  (xd_rem[i+1]),
			.out_num  (xd_num[i+1]),
			.out_den  (xd_den[i+1]),
			.out_side (xd_side[i+1])
		);
	end

	// Stage 12: offset takes the sign of the focus offset.
	x_side_t                xside_end;
	x_side_t                xside_s12;
	logic signed [PPW:0]    xq_s12;

	assign xside_end = xd_side[PPW];

	always_ff @(posedge clk) begin
		if (adv) begin
			xside_s12 <= xside_end;
			xq_s12    <= xside_end.tail.pneg ? (PPW+1)'(-{1'b0, xd_num[PPW]})
			                                 : (PPW+1)'({1'b0, xd_num[PPW]});
		end
	end

	// Stage 13: add the midpoint, saturate and register the output word.
	logic signed [PSW-1:0] xs_c;
	logic                  ovx_c;
	logic signed [W-1:0]   xsat_c;
	logic                  zero_c;

	assign xs_c   = PSW'(xq_s12) + PSW'(xside_s12.tail.hf);
	assign ovx_c  = !((&xs_c[PSW-1:W-1]) || !(|xs_c[PSW-1:W-1]));
	assign xsat_c = ovx_c ? (xs_c[PSW-1] ? MINV : MAXV) : xs_c[W-1:0];
	assign zero_c = (xside_s12.tail.kind == KIND_ZERO);

	always_ff @(posedge clk) begin
		if (adv) begin
			point_x <= zero_c ? '0 : xsat_c;
			point_y <= zero_c ? '0 : xside_s12.y;
			status  <= xside_s12.tail.status;
		end
	end

	// Valid bits of the plain stages and of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			point_valid <= 1'b0;
		end else if (adv) begin
			v_s1        <= item_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= lim_vld[LNW];
			v_s6        <= rt_vld[K];
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= yd_vld[NYW];
			v_s10       <= v_s9;
			v_s11       <= v_s10;
			v_s12       <= xd_vld[PPW];
			point_valid <= v_s12;
		end
	end

	// A fault status always comes with a zero point.
	`PBS_ASSERT_IMP(a_fault_zero, point_valid && (status != ST_OK), (point_x == '0) && (point_y == '0))
	// An accepted word enters the first stage.
	`PBS_ASSERT_NXT(a_accept_s1, item_valid && !item_stall, v_s1)
	// A finished word reaches the output register when the chain moves.
	`PBS_ASSERT_NXT(a_drain_out, v_s12 && adv, point_valid)

endmodule
